// ----- design/tcw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes, the queued operation type and the character filter
// for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF     = 80;
    localparam int ROWS_DEF        = 25;
    localparam int QUEUE_DEPTH_DEF = 2;

    // largest geometry the field widths below must hold
    localparam int ROWS_MAX    = 64;
    localparam int COLUMNS_MAX = 128;
    localparam int ROW_W       = $clog2(ROWS_MAX);
    localparam int COL_W       = $clog2(COLUMNS_MAX);

    // port field widths
    localparam int OUT_ROW_W = 5;
    localparam int OUT_COL_W = 7;
    localparam int BYTE_W    = 8;
    localparam int CELL_W    = 2 * BYTE_W;

    // command codes on the input
    localparam logic [1:0] CMD_PUT  = 2'd0;
    localparam logic [1:0] CMD_CELL = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    // operation codes handed to the back end
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // characters and attributes
    localparam logic [BYTE_W-1:0] CHAR_BLANK   = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_QMARK   = 8'h3f;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [BYTE_W-1:0] COLOR_RESET  = 8'h07;
    localparam logic [CELL_W-1:0] CELL_RESET   = {COLOR_RESET, CHAR_BLANK};

    // one item as the back end carries it out, rows and columns are physical
    typedef struct packed {
        logic [1:0]           kind;
        logic [ROW_W-1:0]     row;
        logic [COL_W-1:0]     col;
        logic [CELL_W-1:0]    cell_data;
        logic                 fill;
        logic [ROW_W-1:0]     fill_row;
        logic [BYTE_W-1:0]    fill_color;
        logic [OUT_ROW_W-1:0] cur_row;
        logic [OUT_COL_W-1:0] cur_col;
    } tcw_op_t;

    // printable set, plus newline, accepted at the cursor
    function automatic logic char_allowed(input logic [BYTE_W-1:0] c);
        return c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39],
                         8'h2f, 8'h2a, 8'h2d, 8'h2b, 8'h2e, 8'h0a, 8'h2c,
                         8'h3c, 8'h3e, 8'h3f, 8'h3a, 8'h5f, 8'h22, 8'h3b,
                         8'h27, 8'h21, 8'h5c, 8'h7c, 8'h5b, 8'h5d, 8'h7b,
                         8'h7d, 8'h28, 8'h29, 8'h60, 8'h20};
    endfunction

endpackage

// ----- design/tcw_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accepts items, filters characters, moves the cursor, keeps the scroll base
// and turns each item into one operation on physical rows for the back end.
// ----------------------------------------------------------------------------
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           cmd,
    input  logic [BYTE_W-1:0]    char_code,
    input  logic [BYTE_W-1:0]    cell_color,
    input  logic [6:0]           pos_x,
    input  logic [4:0]           pos_y,
    input  logic                 cfg_we,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 q_full,
    input  logic                 clearing,
    output logic                 push,
    output tcw_op_t              push_op
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);

    logic [RW-1:0]     cur_row_reg, cur_row_next;
    logic [CW-1:0]     cur_col_reg, cur_col_next;
    logic [RW-1:0]     base_reg, base_next;
    logic [BYTE_W-1:0] text_color_reg;

    logic [BYTE_W-1:0] ch_f;
    logic [CW:0]       col_inc;
    logic              brk;
    logic              pos_ok;

    // logical row to physical row through the scroll base
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                               input logic [RW-1:0] b);
        logic [RW:0] s;
        s = {1'b0, r} + {1'b0, b};
        if (s >= (RW+1)'(ROWS))
        begin
            s = s - (RW+1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

    assign busy = q_full || clearing;
    assign push = start && !busy;

    // classify the item and work out the cursor
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        base_next    = base_reg;
        brk          = 1'b0;
        ch_f         = char_allowed(char_code) ? char_code : CHAR_QMARK;
        col_inc      = {1'b0, cur_col_reg} + (CW+1)'(1);
        pos_ok       = ({1'b0, pos_x} < 8'(COLUMNS)) && ({2'b00, pos_y} < 7'(ROWS));

        push_op            = '0;
        push_op.kind       = OP_NONE;
        push_op.fill_color = text_color_reg;
        push_op.fill_row   = ROW_W'(base_reg);

        unique case (cmd)
            CMD_PUT:
            begin
                if (ch_f == CHAR_NEWLINE)
                begin
                    brk = 1'b1;
                end
                else
                begin
                    push_op.kind      = OP_WRITE;
                    push_op.row       = ROW_W'(phys_row(cur_row_reg, base_reg));
                    push_op.col       = COL_W'(cur_col_reg);
                    push_op.cell_data = {text_color_reg, ch_f};
                    if (col_inc == (CW+1)'(COLUMNS))
                    begin
                        brk = 1'b1;
                    end
                    else
                    begin
                        cur_col_next = col_inc[CW-1:0];
                    end
                end
            end
            CMD_CELL:
            begin
                if (pos_ok)
                begin
                    push_op.kind      = OP_WRITE;
                    push_op.row       = ROW_W'(phys_row(RW'(pos_y), base_reg));
                    push_op.col       = COL_W'(pos_x);
                    push_op.cell_data = {cell_color, char_code};
                end
            end
            CMD_READ:
            begin
                if (pos_ok)
                begin
                    push_op.kind = OP_READ;
                    push_op.row  = ROW_W'(phys_row(RW'(pos_y), base_reg));
                    push_op.col  = COL_W'(pos_x);
                end
            end
            CMD_NOP:
            begin
                push_op.kind = OP_NONE;
            end
        endcase

        // line break, scrolling by moving the base on the last row
        if (brk)
        begin
            cur_col_next = '0;
            if (cur_row_reg >= RW'(ROWS - 1))
            begin
                cur_row_next = RW'(ROWS - 1);
                push_op.fill = 1'b1;
                base_next    = (base_reg == RW'(ROWS - 1)) ? '0 : base_reg + RW'(1);
            end
            else
            begin
                cur_row_next = cur_row_reg + RW'(1);
            end
        end

        push_op.cur_row = OUT_ROW_W'(cur_row_next);
        push_op.cur_col = OUT_COL_W'(cur_col_next);
    end

    // cursor, base and colour registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            base_reg       <= '0;
            text_color_reg <= COLOR_RESET;
        end
        else
        begin
            if (push)
            begin
                cur_row_reg <= cur_row_next;
                cur_col_reg <= cur_col_next;
                base_reg    <= base_next;
            end
            if (cfg_we)
            begin
                text_color_reg <= cfg_data;
            end
        end
    end

    // cursor and base stay on screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_row_reg < ROWS && base_reg < ROWS && cur_col_reg < COLUMNS)
        else $error("cursor or scroll base off screen");

endmodule

// ----- design/tcw_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue
// Short first-in first-out queue of operations between front and back end.
// ----------------------------------------------------------------------------
module tcw_queue
    import tcw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  tcw_op_t push_op,
    input  logic    pop,
    output logic    full,
    output logic    valid,
    output tcw_op_t head
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    tcw_op_t         slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0] count_reg, count_next;

    assign valid = (count_reg != '0);
    assign full  = (count_reg == CNTW'(DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    // pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

endmodule

// ----- design/tcw_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Owns the screen memory: clears it after reset, carries out queued writes,
// reads and bottom-row fills, and drives one result per item.
// ----------------------------------------------------------------------------
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  tcw_op_t              head,
    output logic                 pop,
    output logic                 clearing,
    output logic                 done,
    output logic [OUT_ROW_W-1:0] cursor_row,
    output logic [OUT_COL_W-1:0] cursor_col,
    output logic [BYTE_W-1:0]    read_char,
    output logic [BYTE_W-1:0]    read_color,
    output logic                 scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_FILL  = 2'd3;

    logic [CELL_W-1:0] mem [CELLS];

    logic [1:0]           state_reg, state_next;
    logic [AW-1:0]        cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    tcw_op_t              op_reg;
    logic [CELL_W-1:0]    rd_data_reg;
    logic [OUT_ROW_W-1:0] cursor_row_reg, cursor_row_next;
    logic [OUT_COL_W-1:0] cursor_col_reg, cursor_col_next;
    logic [BYTE_W-1:0]    read_char_reg, read_char_next;
    logic [BYTE_W-1:0]    read_color_reg, read_color_next;
    logic                 scrolled_reg, scrolled_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic [CELL_W-1:0]    mem_wdata;
    logic [ROW_W-1:0]     sel_row;
    logic [COL_W-1:0]     sel_col;
    logic [AW-1:0]        sel_addr;

    // cell address from physical row and column
    function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
        return AW'(r) * AW'(COLUMNS) + AW'(c);
    endfunction

    assign clearing   = (state_reg == ST_CLEAR);
    assign pop        = (state_reg == ST_IDLE) && q_valid;
    assign done       = done_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;
    assign read_char  = read_char_reg;
    assign read_color = read_color_reg;
    assign scrolled   = scrolled_reg;

    // memory port selection
    always_comb
    begin
        sel_row   = head.row;
        sel_col   = head.col;
        mem_we    = 1'b0;
        mem_wdata = head.cell_data;
        if (state_reg == ST_FILL)
        begin
            sel_row = op_reg.fill_row;
            sel_col = COL_W'(cnt_reg);
        end
        sel_addr  = cell_addr(sel_row, sel_col);
        mem_waddr = sel_addr;
        mem_raddr = sel_addr;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = CELL_RESET;
            end
            ST_IDLE:
            begin
                mem_we = q_valid && (head.kind == OP_WRITE);
            end
            ST_READ:
            begin
                mem_we = 1'b0;
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = {op_reg.fill_color, CHAR_BLANK};
            end
        endcase
    end

    // sequencer and result selection
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        done_next       = 1'b0;
        cursor_row_next = op_reg.cur_row;
        cursor_col_next = op_reg.cur_col;
        read_char_next  = '0;
        read_color_next = '0;
        scrolled_next   = op_reg.fill;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cursor_row_next = head.cur_row;
                cursor_col_next = head.cur_col;
                scrolled_next   = 1'b0;
                if (q_valid)
                begin
                    if (head.kind == OP_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (head.fill)
                    begin
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                read_char_next  = rd_data_reg[BYTE_W-1:0];
                read_color_next = rd_data_reg[CELL_W-1:BYTE_W];
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_FILL:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(COLUMNS - 1))
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= head;
        end
        if (done_next)
        begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            read_char_reg  <= read_char_next;
            read_color_reg <= read_color_next;
            scrolled_reg   <= scrolled_next;
        end
    end

    // screen memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !done_reg)
        else $error("result during clearing pass");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |-> cnt_reg < COLUMNS)
        else $error("fill ran past the last column");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && scrolled_reg |-> cursor_row_reg == OUT_ROW_W'(ROWS - 1))
        else $error("scroll reported off the last row");

endmodule

// ----- design/text_console_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode screen store with a cursor, scrolling and cell read and write.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low, with cmd, char_code, cell_color,
//   pos_x and pos_y. Each item gives one result, shown for one cycle with done
//   high; the receiver cannot hold it off, so results never wait.
//   Write the attribute register (cfg_we, cfg_data) only while idle; unenforced.
// Results: a write or no-op item is popped from the queue and its result is
//   registered in done; a read first waits in a read state. A scrolling item
//   adds the bottom row fill; scrolling itself only moves a row base register.
// Throughput: one write item per cycle while busy is low. A read holds the
//   back end in its read state and a scrolling item in the fill, which uses the
//   single write port of the screen memory. A two-entry queue lets new items
//   in while the memory side works; busy rises when it is full.
// Reset: cursor, base and attribute return to their reset values, then a
//   clearing pass writes all ROWS * COLUMNS cells (2000 by default) with blanks
//   in light grey on black with busy held high.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS     = COLUMNS_DEF,
    parameter int ROWS        = ROWS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           cmd,
    input  logic [BYTE_W-1:0]    char_code,
    input  logic [BYTE_W-1:0]    cell_color,
    input  logic [6:0]           pos_x,
    input  logic [4:0]           pos_y,
    input  logic                 cfg_we,
    input  logic [BYTE_W-1:0]    cfg_data,
    output logic                 done,
    output logic [OUT_ROW_W-1:0] cursor_row,
    output logic [OUT_COL_W-1:0] cursor_col,
    output logic [BYTE_W-1:0]    read_char,
    output logic [BYTE_W-1:0]    read_color,
    output logic                 scrolled
);

    logic    push;
    tcw_op_t push_op;
    logic    pop;
    logic    q_full;
    logic    q_valid;
    tcw_op_t head;
    logic    clearing;

    // item intake and cursor
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .char_code  (char_code),
        .cell_color (cell_color),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (push),
        .push_op    (push_op)
    );

    // operation queue
    tcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .full    (q_full),
        .valid   (q_valid),
        .head    (head)
    );

    // screen memory and results
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .head       (head),
        .pop        (pop),
        .clearing   (clearing),
        .done       (done),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .read_char  (read_char),
        .read_color (read_color),
        .scrolled   (scrolled)
    );

endmodule
